>>> hdl/slfw_pkg.sv
// Shared types, command codes and segment tables for the segment LCD frame writer.
`default_nettype none
package slfw_pkg;

  // Largest frame the datapath is built for
  localparam int FRAME_MAX = 16;
  localparam int DIGIT_POSITIONS = 6;

  // Request kinds carried on s_tuser
  localparam logic [1:0] REQ_CHAR  = 2'd0;
  localparam logic [1:0] REQ_VALUE = 2'd1;
  localparam logic [1:0] REQ_BARS  = 2'd2;

  // Segment constants
  localparam logic [15:0] SEG_MU      = 16'h6081;
  localparam logic [15:0] SEG_SMALL_M = 16'hb210;
  localparam logic [15:0] SEG_SMALL_N = 16'h2210;
  localparam logic [15:0] SEG_STAR    = 16'hA0D7;
  localparam logic [15:0] SEG_MINUS   = 16'hA000;
  localparam logic [15:0] SEG_POINT   = 16'h0008;
  localparam logic [15:0] SEG_COLON   = 16'h0020;

  // Reciprocals for division by ten and by one hundred
  localparam logic [31:0] RECIP_10  = 32'hCCCCCCCD;
  localparam logic [31:0] RECIP_100 = 32'h51EB851F;
  localparam int SHIFT_10  = 35;
  localparam int SHIFT_100 = 37;

  // Datapath command codes
  localparam logic [3:0] CMD_NONE   = 4'd0;
  localparam logic [3:0] CMD_LOAD   = 4'd1;
  localparam logic [3:0] CMD_EXEC   = 4'd2;
  localparam logic [3:0] CMD_MUL100 = 4'd3;
  localparam logic [3:0] CMD_DROP   = 4'd4;
  localparam logic [3:0] CMD_OL     = 4'd5;
  localparam logic [3:0] CMD_MUL10  = 4'd6;
  localparam logic [3:0] CMD_DIGIT  = 4'd7;
  localparam logic [3:0] CMD_READ   = 4'd8;

  typedef struct packed {
    logic [3:0] op;
  } slfw_cmd_t;

  typedef struct packed {
    logic value_req;
    logic ovf;
    logic j_last;
    logic read_last;
    logic out_free;
  } slfw_sts_t;

  // Per-byte write mask and data for one frame update
  typedef struct packed {
    logic [FRAME_MAX-1:0][7:0] mask;
    logic [FRAME_MAX-1:0][7:0] val;
  } frame_upd_t;

  function automatic logic [15:0] letter_seg(input logic [4:0] i);
    logic [15:0] s;
    unique case (i)
      5'd0:  s = 16'hFE00;
      5'd1:  s = 16'h6711;
      5'd2:  s = 16'h1d00;
      5'd3:  s = 16'h4711;
      5'd4:  s = 16'h9d00;
      5'd5:  s = 16'h9c00;
      5'd6:  s = 16'h3f00;
      5'd7:  s = 16'hfa00;
      5'd8:  s = 16'h0011;
      5'd9:  s = 16'h5300;
      5'd10: s = 16'h9844;
      5'd11: s = 16'h1900;
      5'd12: s = 16'h5a42;
      5'd13: s = 16'h5a06;
      5'd14: s = 16'h5f00;
      5'd15: s = 16'hFC00;
      5'd16: s = 16'h5F04;
      5'd17: s = 16'hFC04;
      5'd18: s = 16'hAF00;
      5'd19: s = 16'h0411;
      5'd20: s = 16'h5b00;
      5'd21: s = 16'h18c0;
      5'd22: s = 16'h5a84;
      5'd23: s = 16'h00c6;
      5'd24: s = 16'h0052;
      5'd25: s = 16'h05c0;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] digit_seg(input logic [3:0] d);
    logic [15:0] s;
    unique case (d)
      4'd0: s = 16'h5F00;
      4'd1: s = 16'h4200;
      4'd2: s = 16'hF500;
      4'd3: s = 16'h6700;
      4'd4: s = 16'hEa00;
      4'd5: s = 16'hAF00;
      4'd6: s = 16'hBF00;
      4'd7: s = 16'h4600;
      4'd8: s = 16'hFF00;
      4'd9: s = 16'hEF00;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

  // Map a character byte to its segment code
  function automatic logic [15:0] char_seg(input logic [7:0] c);
    logic [15:0] s;
    priority if (c == 8'h20) s = 16'h0000;
    else if (c == 8'h2A) s = SEG_STAR;
    else if (c == 8'hB5) s = SEG_MU;
    else if (c == 8'h6D) s = SEG_SMALL_M;
    else if (c == 8'h6E) s = SEG_SMALL_N;
    else if (c == 8'h2D) s = SEG_MINUS;
    else if (c >= 8'h30 && c <= 8'h39) s = digit_seg(4'(c - 8'h30));
    else if (c >= 8'h41 && c <= 8'h5A) s = letter_seg(5'(c - 8'h41));
    else if (c >= 8'h61 && c <= 8'h7A) s = letter_seg(5'(c - 8'h61));
    else s = 16'h0000;
    return s;
  endfunction

  function automatic frame_upd_t put(input frame_upd_t u, input int idx,
                                     input logic [7:0] m, input logic [15:0] v);
    frame_upd_t r;
    r = u;
    r.mask[idx] = u.mask[idx] | m;
    r.val[idx]  = (u.val[idx] & ~m) | (v[7:0] & m);
    return r;
  endfunction

  // Scatter the four nibbles of a segment code into the frame bytes of one position
  function automatic frame_upd_t seg_scatter(input logic [15:0] code, input logic [2:0] pos);
    frame_upd_t u;
    logic [15:0] n0, n1, n2, n3;
    u  = '0;
    n0 = {12'd0, code[15:12]};
    n1 = {12'd0, code[11:8]};
    n2 = {12'd0, code[7:4]};
    n3 = {12'd0, code[3:0]};
    unique case (pos)
      3'd1: begin
        u = put(u, 0, 8'h03, n0);       u = put(u, 2, 8'hc0, n0 << 4);
        u = put(u, 3, 8'h30, n1 << 4);  u = put(u, 6, 8'h0c, n1);
        u = put(u, 7, 8'h03, n2);       u = put(u, 9, 8'hc0, n2 << 4);
        u = put(u, 10, 8'h30, n3 << 2); u = put(u, 13, 8'h0c, n3 << 2);
      end
      3'd2: begin
        u = put(u, 0, 8'h0c, n0 << 2);  u = put(u, 2, 8'h30, n0 << 2);
        u = put(u, 3, 8'hc0, n1 << 6);  u = put(u, 6, 8'h03, n1 >> 2);
        u = put(u, 7, 8'h0c, n2 << 2);  u = put(u, 9, 8'h30, n2 << 2);
        u = put(u, 10, 8'hc0, n3 << 4); u = put(u, 13, 8'h03, n3);
      end
      3'd3: begin
        u = put(u, 0, 8'h30, n0 << 4);  u = put(u, 2, 8'h0c, n0);
        u = put(u, 4, 8'h03, n1);       u = put(u, 5, 8'hc0, n1 << 4);
        u = put(u, 7, 8'h30, n2 << 4);  u = put(u, 9, 8'h0c, n2);
        u = put(u, 11, 8'h03, n3 >> 2); u = put(u, 12, 8'hc0, n3 << 6);
      end
      3'd4: begin
        u = put(u, 0, 8'hc0, n0 << 6);  u = put(u, 2, 8'h03, n0 >> 2);
        u = put(u, 4, 8'h0c, n1 << 2);  u = put(u, 5, 8'h30, n1 << 2);
        u = put(u, 7, 8'hc0, n2 << 6);  u = put(u, 9, 8'h03, n2 >> 2);
        u = put(u, 11, 8'h0c, n3);      u = put(u, 12, 8'h30, n3 << 4);
      end
      3'd5: begin
        u = put(u, 1, 8'h03, n0);       u = put(u, 1, 8'hc0, n0 << 4);
        u = put(u, 4, 8'h30, n1 << 4);  u = put(u, 5, 8'h0c, n1);
        u = put(u, 8, 8'h01, n2);       u = put(u, 8, 8'hc0, n2 << 4);
        u = put(u, 11, 8'h10, n3 << 2); u = put(u, 12, 8'h0c, n3 << 2);
      end
      3'd6: begin
        u = put(u, 1, 8'h0c, n0 << 2);  u = put(u, 1, 8'h30, n0 << 2);
        u = put(u, 4, 8'hc0, n1 << 6);  u = put(u, 5, 8'h03, n1 >> 2);
        u = put(u, 8, 8'h04, n2 << 2);  u = put(u, 8, 8'h30, n2 << 2);
        u = put(u, 11, 8'h40, n3 << 4); u = put(u, 12, 8'h03, n3);
      end
      default: u = '0;
    endcase
    return u;
  endfunction

  // Display limit for the number of digit slots, one decade less when negative
  function automatic logic [23:0] value_limit(input logic [1:0] start, input logic neg);
    logic [23:0] l;
    unique case (start)
      2'd2:    l = neg ? 24'd10000  : 24'd100000;
      2'd3:    l = neg ? 24'd1000   : 24'd10000;
      default: l = neg ? 24'd1000000 : 24'd10000000;
    endcase
    return l;
  endfunction

endpackage
`default_nettype wire

>>> hdl/slfw_datapath.sv
// Frame storage, value formatting registers and readout register of the frame writer.
`default_nettype none
module slfw_datapath
  import slfw_pkg::*;
#(
  parameter int FRAME_BYTES = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire slfw_cmd_t   cmd,
  output slfw_sts_t        sts,
  input  wire logic [71:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  output logic             m_tlast
);

  localparam int IW = $clog2(FRAME_BYTES);

  logic [FRAME_BYTES-1:0][7:0] frame;
  logic [FRAME_BYTES-1:0][7:0] frame_next;

  // Captured request
  logic [1:0]  req_type;
  logic [7:0]  char_code;
  logic        dot_on;
  logic        colon_on;
  logic [2:0]  position;
  logic [7:0]  name_first;
  logic [7:0]  name_second;
  logic [3:0]  bar_bits;

  // Value formatting state
  logic [31:0] mag;
  logic [31:0] quo;
  logic        neg;
  logic        pt;
  logic [1:0]  start;
  logic [2:0]  j;
  logic [IW-1:0] idx;

  logic [31:0] num_in;
  logic [63:0] prod;
  logic [31:0] rem;
  logic [3:0]  digit;
  logic        blank_lead;
  logic [15:0] digit_code;
  logic [15:0] ol_code;
  logic        over;
  frame_upd_t  upd_a;
  logic [15:0] bar_code_a;
  frame_upd_t  upd_b;

  assign num_in = s_tdata[44:13];

  // Shared reciprocal multiplier
  assign prod = mag * ((cmd.op == CMD_MUL100) ? RECIP_100 : RECIP_10);

  // Digit and leading-zero handling
  assign rem        = mag - ((quo << 3) + (quo << 1));
  assign digit      = rem[3:0];
  assign blank_lead = (quo == 32'd0) && (digit == 4'd0) && ((j < 3'd4) || !pt);

  always_comb begin
    if (blank_lead) begin
      if (j == 3'd6) digit_code = digit_seg(4'd0);
      else           digit_code = neg ? SEG_MINUS : 16'h0000;
    end else begin
      digit_code = digit_seg(digit) | ((pt && (j == 3'd4)) ? SEG_POINT : 16'h0000);
    end
  end

  // Overflow text: blank, O, L, blank
  always_comb begin
    unique case (j)
      3'd5:    ol_code = char_seg(8'h4C);
      3'd4:    ol_code = char_seg(8'h4F);
      default: ol_code = 16'h0000;
    endcase
  end

  assign over = (mag >= {8'd0, value_limit(start, neg)});
  assign bar_code_a = 16'h0000;

  // Select the frame updates for this command
  always_comb begin
    upd_a = '0;
    upd_b = '0;
    unique case (cmd.op)
      CMD_EXEC: begin
        unique case (req_type)
          REQ_CHAR: upd_a = seg_scatter(char_seg(char_code)
                                        | (dot_on ? SEG_POINT : bar_code_a)
                                        | (colon_on ? SEG_COLON : bar_code_a), position);
          REQ_VALUE: begin
            if (name_first != 8'd0) begin
              if (name_second == 8'd0) begin
                upd_a = seg_scatter(char_seg(name_first) | SEG_COLON, 3'd1);
              end else begin
                upd_a = seg_scatter(char_seg(name_first), 3'd1);
                upd_b = seg_scatter(char_seg(name_second) | SEG_COLON, 3'd2);
              end
            end
          end
          REQ_BARS: begin
            upd_a = put(upd_a, 11, 8'h80, bar_bits[0] ? 16'h0080 : 16'h0000);
            upd_a = put(upd_a, 11, 8'h20, bar_bits[2] ? 16'h0020 : 16'h0000);
            upd_a = put(upd_a, 8, 8'h02, bar_bits[3] ? 16'h0002 : 16'h0000);
            upd_a = put(upd_a, 8, 8'h08, bar_bits[1] ? 16'h0008 : 16'h0000);
          end
          default: upd_a = '0;
        endcase
      end
      CMD_OL:    upd_a = seg_scatter(ol_code, j);
      CMD_DIGIT: upd_a = seg_scatter(digit_code, j);
      default:   upd_a = '0;
    endcase
  end

  // Apply both updates in order
  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      frame_next[i] = (frame[i] & ~upd_a.mask[i]) | (upd_a.val[i] & upd_a.mask[i]);
      frame_next[i] = (frame_next[i] & ~upd_b.mask[i]) | (upd_b.val[i] & upd_b.mask[i]);
    end
  end

  // Hold the frame, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else begin
      frame <= frame_next;
    end
  end

  // Capture the request and step the formatting registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LOAD: begin
        req_type    <= s_tuser;
        char_code   <= s_tdata[7:0];
        dot_on      <= s_tdata[8];
        colon_on    <= s_tdata[9];
        position    <= s_tdata[12:10];
        name_first  <= s_tdata[52:45];
        name_second <= s_tdata[60:53];
        bar_bits    <= s_tdata[64:61];
        neg         <= num_in[31];
        mag         <= num_in[31] ? (~num_in + 32'd1) : num_in;
        pt          <= s_tdata[8];
        j           <= 3'd6;
        if (s_tdata[52:45] == 8'd0)      start <= 2'd0;
        else if (s_tdata[60:53] == 8'd0) start <= 2'd2;
        else                             start <= 2'd3;
      end
      CMD_MUL100: quo <= 32'(prod >> SHIFT_100);
      CMD_MUL10:  quo <= 32'(prod >> SHIFT_10);
      CMD_DROP: begin
        if (over && pt) begin
          mag <= quo;
          pt  <= 1'b0;
        end
      end
      CMD_OL: j <= j - 3'd1;
      CMD_DIGIT: begin
        mag <= quo;
        neg <= neg & ~blank_lead;
        j   <= j - 3'd1;
      end
      default: begin
      end
    endcase
  end

  // Readout counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.op == CMD_READ) begin
      idx <= sts.read_last ? '0 : idx + IW'(1);
    end
  end

  // Output register: load a frame byte, drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == CMD_READ) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_READ) begin
      m_tdata <= {4'd0, frame[idx], 4'(idx)};
      m_tlast <= sts.read_last;
    end
  end

  assign sts.value_req = (req_type == REQ_VALUE);
  assign sts.ovf       = over;
  assign sts.j_last    = (j == {1'b0, start}) || (j == 3'd0);
  assign sts.read_last = (idx == IW'(FRAME_BYTES - 1));
  assign sts.out_free  = !m_tvalid || m_tready;

endmodule
`default_nettype wire

>>> hdl/slfw_ctrl.sv
// Request sequencer of the frame writer.
`default_nettype none
module slfw_ctrl
  import slfw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  output slfw_cmd_t      cmd,
  input  wire slfw_sts_t sts
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_MUL100 = 4'd2;
  localparam logic [3:0] S_DROP   = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_OL     = 4'd5;
  localparam logic [3:0] S_MUL10  = 4'd6;
  localparam logic [3:0] S_DIGIT  = 4'd7;
  localparam logic [3:0] S_READ   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == S_IDLE);

  // Next state and command
  always_comb begin
    state_next = state;
    cmd.op     = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = CMD_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.op     = CMD_EXEC;
        state_next = sts.value_req ? S_MUL100 : S_READ;
      end
      S_MUL100: begin
        cmd.op     = CMD_MUL100;
        state_next = S_DROP;
      end
      S_DROP: begin
        cmd.op     = CMD_DROP;
        state_next = S_CHECK;
      end
      S_CHECK: state_next = sts.ovf ? S_OL : S_MUL10;
      S_OL: begin
        cmd.op     = CMD_OL;
        state_next = sts.j_last ? S_READ : S_OL;
      end
      S_MUL10: begin
        cmd.op     = CMD_MUL10;
        state_next = S_DIGIT;
      end
      S_DIGIT: begin
        cmd.op     = CMD_DIGIT;
        state_next = sts.j_last ? S_READ : S_MUL10;
      end
      S_READ: begin
        if (sts.out_free) begin
          cmd.op = CMD_READ;
          if (sts.read_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_read_has_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_READ) |-> sts.out_free) else $error("readout into a full output register");
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC)) else $error("accepted request not executed");
  a_digits_end_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT && sts.j_last) |=> (state == S_READ)) else $error("digit loop overran");
`endif

endmodule
`default_nettype wire

>>> hdl/segment_lcd_frame_writer_core.sv
// Top level of the segment LCD frame writer.
// Each request updates a FRAME_BYTES-byte segment frame (cleared at reset) and then
// streams the whole frame out, one byte per transfer, with tlast on the final byte.
// A character or bar request is loaded and written, then read out; a value display
// also divides by one hundred when a value with its point on overflows, checks for
// overflow, then per digit slot does one shared 32x32 reciprocal multiply and one
// frame write, or one frame write per position for the overflow text. Readout waits
// while the sink is not ready; a new request is taken only after its readout.
`default_nettype none
module segment_lcd_frame_writer_core
  import slfw_pkg::*;
#(
  parameter int FRAME_BYTES = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // char_code[7:0], dot_on[8], colon_on[9], position[12:10], number_value[44:13],
  // name_first[52:45], name_second[60:53], bar_bits[64:61]
  input  wire logic [71:0] s_tdata,
  // req_type[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // ram_index[3:0], ram_byte[11:4]
  output logic [15:0]      m_tdata,
  output logic             m_tlast
);

  slfw_cmd_t cmd;
  slfw_sts_t sts;

  slfw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  slfw_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

>>> sim/segment_lcd_frame_checker.sv
// Frame predictor and readout checker for the segment LCD frame writer.
`timescale 1ns / 1ps
module segment_lcd_frame_checker
  import slfw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [71:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [15:0] m_tdata,
  input  wire logic        m_tlast,
  output int               fail_count,
  output int               pending
);
  localparam int NBYTES = 14;

  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic [7:0] lcd_ram [NBYTES];
  frame_byte_t readout_q[$];

  assign pending = readout_q.size();

  // Segment code for one character byte
  function automatic logic [15:0] glyph(input logic [7:0] c);
    logic [15:0] letters [26];
    logic [15:0] digits [10];
    letters = '{16'hFE00, 16'h6711, 16'h1d00, 16'h4711, 16'h9d00, 16'h9c00, 16'h3f00,
                16'hfa00, 16'h0011, 16'h5300, 16'h9844, 16'h1900, 16'h5a42, 16'h5a06,
                16'h5f00, 16'hFC00, 16'h5F04, 16'hFC04, 16'hAF00, 16'h0411, 16'h5b00,
                16'h18c0, 16'h5a84, 16'h00c6, 16'h0052, 16'h05c0};
    digits = '{16'h5F00, 16'h4200, 16'hF500, 16'h6700, 16'hEa00, 16'hAF00, 16'hBF00,
               16'h4600, 16'hFF00, 16'hEF00};
    if (c == 8'h20) return 16'h0000;
    if (c == 8'h2A) return SEG_STAR;
    if (c == 8'hB5) return SEG_MU;
    if (c == 8'h6D) return SEG_SMALL_M;
    if (c == 8'h6E) return SEG_SMALL_N;
    if (c == 8'h2D) return SEG_MINUS;
    if (c >= 8'h30 && c <= 8'h39) return digits[c - 8'h30];
    if (c >= 8'h41 && c <= 8'h5A) return letters[c - 8'h41];
    if (c >= 8'h61 && c <= 8'h7A) return letters[c - 8'h61];
    return 16'h0000;
  endfunction

  task automatic merge(input int i, input logic [7:0] m, input logic [15:0] v);
    lcd_ram[i] = (lcd_ram[i] & ~m) | (v[7:0] & m);
  endtask

  task automatic draw(input logic [7:0] c, input bit pt, input bit col, input int pos);
    logic [15:0] code;
    logic [15:0] n0, n1, n2, n3;
    code = glyph(c) | (pt ? SEG_POINT : 16'h0) | (col ? SEG_COLON : 16'h0);
    n0 = {12'd0, code[15:12]};
    n1 = {12'd0, code[11:8]};
    n2 = {12'd0, code[7:4]};
    n3 = {12'd0, code[3:0]};
    case (pos)
      1: begin
        merge(0, 8'h03, n0);       merge(2, 8'hc0, n0 << 4);
        merge(3, 8'h30, n1 << 4);  merge(6, 8'h0c, n1);
        merge(7, 8'h03, n2);       merge(9, 8'hc0, n2 << 4);
        merge(10, 8'h30, n3 << 2); merge(13, 8'h0c, n3 << 2);
      end
      2: begin
        merge(0, 8'h0c, n0 << 2);  merge(2, 8'h30, n0 << 2);
        merge(3, 8'hc0, n1 << 6);  merge(6, 8'h03, n1 >> 2);
        merge(7, 8'h0c, n2 << 2);  merge(9, 8'h30, n2 << 2);
        merge(10, 8'hc0, n3 << 4); merge(13, 8'h03, n3);
      end
      3: begin
        merge(0, 8'h30, n0 << 4);  merge(2, 8'h0c, n0);
        merge(4, 8'h03, n1);       merge(5, 8'hc0, n1 << 4);
        merge(7, 8'h30, n2 << 4);  merge(9, 8'h0c, n2);
        merge(11, 8'h03, n3 >> 2); merge(12, 8'hc0, n3 << 6);
      end
      4: begin
        merge(0, 8'hc0, n0 << 6);  merge(2, 8'h03, n0 >> 2);
        merge(4, 8'h0c, n1 << 2);  merge(5, 8'h30, n1 << 2);
        merge(7, 8'hc0, n2 << 6);  merge(9, 8'h03, n2 >> 2);
        merge(11, 8'h0c, n3);      merge(12, 8'h30, n3 << 4);
      end
      5: begin
        merge(1, 8'h03, n0);       merge(1, 8'hc0, n0 << 4);
        merge(4, 8'h30, n1 << 4);  merge(5, 8'h0c, n1);
        merge(8, 8'h01, n2);       merge(8, 8'hc0, n2 << 4);
        merge(11, 8'h10, n3 << 2); merge(12, 8'h0c, n3 << 2);
      end
      6: begin
        merge(1, 8'h0c, n0 << 2);  merge(1, 8'h30, n0 << 2);
        merge(4, 8'hc0, n1 << 6);  merge(5, 8'h03, n1 >> 2);
        merge(8, 8'h04, n2 << 2);  merge(8, 8'h30, n2 << 2);
        merge(11, 8'h40, n3 << 4); merge(12, 8'h03, n3);
      end
      default: ;
    endcase
  endtask

  // Format a signed decimal with optional name, point and overflow text
  task automatic show_number(input logic [31:0] raw, input logic [7:0] first,
                             input logic [7:0] second, input bit pt);
    bit neg;
    logic [31:0] mag, lim;
    int start;
    logic [3:0] d;
    neg = raw[31];
    mag = neg ? (~raw + 32'd1) : raw;
    start = 0;
    if (first != 0) begin
      if (second == 0) begin
        draw(first, 0, 1, 1);
        start = 2;
      end else begin
        draw(first, 0, 0, 1);
        draw(second, 0, 1, 2);
        start = 3;
      end
    end
    lim = 1;
    for (int j = DIGIT_POSITIONS; j >= start; j--) lim = lim * 10;
    if (neg) lim = lim / 10;
    if (mag >= lim && pt) begin
      mag = mag / 100;
      pt = 0;
    end
    if (mag >= lim) begin
      if (start < 3) draw(8'h20, 0, 0, 2);
      if (start < 2) draw(8'h20, 0, 0, 1);
      draw(8'h20, 0, 0, 3);
      draw(8'h4F, 0, 0, 4);
      draw(8'h4C, 0, 0, 5);
      draw(8'h20, 0, 0, 6);
    end else begin
      for (int j = DIGIT_POSITIONS; j >= start; j--) begin
        d = 4'(mag % 10);
        mag = mag / 10;
        draw(8'h30 + {4'd0, d}, pt && j == 4, 0, j);
        if (mag == 0 && d == 0 && (j < 4 || !pt)) begin
          if (neg) begin
            draw(8'h2D, 0, 0, j);
            neg = 0;
          end else begin
            draw(8'h20, 0, 0, j);
          end
          if (j == DIGIT_POSITIONS) draw(8'h30, 0, 0, j);
        end
      end
    end
  endtask

  // Predict on request transfers, compare on readout transfers
  always @(posedge clk) begin
    frame_byte_t got, want;
    if (rst) begin
      foreach (lcd_ram[i]) lcd_ram[i] = 8'h00;
      readout_q = {};
      fail_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          REQ_CHAR:  draw(s_tdata[7:0], s_tdata[8], s_tdata[9], int'(s_tdata[12:10]));
          REQ_VALUE: show_number(s_tdata[44:13], s_tdata[52:45], s_tdata[60:53], s_tdata[8]);
          REQ_BARS: begin
            merge(11, 8'h80, s_tdata[61] ? 16'h80 : 16'h0);
            merge(11, 8'h20, s_tdata[63] ? 16'h20 : 16'h0);
            merge(8, 8'h02, s_tdata[64] ? 16'h02 : 16'h0);
            merge(8, 8'h08, s_tdata[62] ? 16'h08 : 16'h0);
          end
          default: ;
        endcase
        for (int k = 0; k < NBYTES; k++)
          readout_q.push_back('{idx: 4'(k), data: lcd_ram[k], last: k == NBYTES - 1});
      end
      if (m_tvalid && m_tready) begin
        got = '{idx: m_tdata[3:0], data: m_tdata[11:4], last: m_tlast};
        if (readout_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected frame byte %p", got);
        end else begin
          want = readout_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("frame byte mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
  end
endmodule

>>> sim/tb_segment_lcd_frame_writer_core.sv
// Stimulus and verdict for the segment LCD frame writer.
`timescale 1ns / 1ps
module tb_segment_lcd_frame_writer_core
  import slfw_pkg::*;
;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = REQ_CHAR;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          cycle_count = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  segment_lcd_frame_writer_core uut (.*);

  segment_lcd_frame_checker chk (.*);

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Randomly stall the readout
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Hold one request until it is taken; valid stays up into the next request
  task automatic send(input logic [1:0] kind, input logic [7:0] c, input bit pt, input bit col,
                      input logic [2:0] pos, input logic [31:0] num, input logic [7:0] nm1,
                      input logic [7:0] nm2, input logic [3:0] bars);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tuser  <= kind;
    s_tdata  <= {7'd0, bars, nm2, nm1, num, pos, col, pt, c};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic rand_request();
    logic [1:0] kind;
    logic [31:0] num;
    logic [7:0] c, nm1, nm2;
    int sel;
    kind = $urandom_range(9) == 0 ? 2'd3 : 2'($urandom_range(2));
    sel = $urandom_range(4);
    num = sel == 0 ? $urandom : sel == 1 ? $urandom_range(999) :
          sel == 2 ? -$urandom_range(99999) : sel == 3 ? $urandom_range(9999999) : 32'd0;
    c = $urandom_range(1) ? 8'($urandom_range(8'h20, 8'h7A)) : 8'($urandom);
    nm1 = $urandom_range(2) == 0 ? 8'h0 : 8'($urandom_range(8'h41, 8'h7A));
    nm2 = $urandom_range(1) ? 8'h0 : 8'($urandom);
    send(kind, c, 1'($urandom_range(1)), 1'($urandom_range(1)), 3'($urandom_range(7)), num,
         nm1, nm2, 4'($urandom_range(15)));
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 0;
    // Directed: every character class, all positions, bars and value corners
    send(REQ_CHAR, 8'h41, 1, 1, 3'd1, 0, 0, 0, 0);
    send(REQ_CHAR, 8'h7A, 0, 1, 3'd2, 0, 0, 0, 0);
    send(REQ_CHAR, 8'h39, 1, 0, 3'd3, 0, 0, 0, 0);
    send(REQ_CHAR, 8'hB5, 0, 0, 3'd4, 0, 0, 0, 0);
    send(REQ_CHAR, 8'h6D, 1, 1, 3'd5, 0, 0, 0, 0);
    send(REQ_CHAR, 8'h2A, 1, 1, 3'd6, 0, 0, 0, 0);
    send(REQ_CHAR, 8'hFF, 1, 1, 3'd0, 0, 0, 0, 0);
    send(REQ_CHAR, 8'h6E, 1, 1, 3'd7, 0, 0, 0, 0);
    send(REQ_BARS, 8'h0, 0, 0, 3'd0, 0, 0, 0, 4'hF);
    send(REQ_CHAR, 8'h2D, 0, 0, 3'd5, 0, 0, 0, 0);
    send(REQ_BARS, 8'h0, 0, 0, 3'd0, 0, 0, 0, 4'h5);
    send(2'd3, 8'hFF, 1, 1, 3'd7, 32'hFFFFFFFF, 8'hFF, 8'hFF, 4'hF);
    send(REQ_VALUE, 0, 0, 0, 0, 32'd0, 0, 0, 0);
    send(REQ_VALUE, 0, 1, 0, 0, -32'sd5, 0, 0, 0);
    send(REQ_VALUE, 0, 0, 0, 0, 32'h80000000, 0, 0, 0);
    send(REQ_VALUE, 0, 0, 0, 0, 32'h7FFFFFFF, 8'h56, 0, 0);
    send(REQ_VALUE, 0, 1, 0, 0, 32'd1234567, 0, 0, 0);
    send(REQ_VALUE, 0, 1, 0, 0, 32'd123456, 8'h76, 8'h61, 0);
    send(REQ_VALUE, 0, 0, 0, 0, -32'sd999, 8'h41, 8'h20, 0);
    send(REQ_VALUE, 0, 1, 0, 0, 32'd42, 8'h49, 0, 0);
    send(REQ_VALUE, 0, 0, 0, 0, 32'd9999999, 0, 0, 0);
    // Random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 56 : (ph == 3) ? 28 : 0;
      recv_stall_pct = (ph == 2) ? 56 : (ph == 3) ? 28 : 0;
      for (int n = 0; n < 38; n++) rand_request();
      // Drain before the next phase
      s_tvalid <= 0;
      while (pending != 0) @(negedge clk);
    end
    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
